// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ptlpb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptlpb_pkg: shared types and constants of the PCIe request TLP builder
// Command codes, TLP header codes, channel widths and the descriptor that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptlpb_pkg;

   // request command codes
   localparam logic [1:0] CMD_CFG_RD = 2'd0;
   localparam logic [1:0] CMD_CFG_WR = 2'd1;
   localparam logic [1:0] CMD_MEM_RD = 2'd2;
   localparam logic [1:0] CMD_MEM_WR = 2'd3;

   // TLP type field codes
   localparam logic [4:0] TLP_TYPE_CFG0 = 5'h04;
   localparam logic [4:0] TLP_TYPE_MEM  = 5'h00;

   // fmt bits
   localparam logic [2:0] FMT_WITH_DATA = 3'h2;
   localparam logic [2:0] FMT_4DW       = 3'h1;

   localparam logic [3:0] MAX_ACCESS_BYTES = 4'd8;

   localparam int MAX_WORDS    = 7;
   localparam int PAY_WORDS    = 3;
   localparam int REQ_TDATA_W  = 152;
   localparam int RSP_TDATA_W  = 40;
   localparam int RID_W        = 16;

   typedef logic [31:0] ptlpb_word_type;

   typedef struct packed {
      ptlpb_word_type [MAX_WORDS-1:0] words;
      logic [2:0]                     last_idx;
      logic [7:0]                     tag;
   } ptlpb_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ptlpb_qstat_type;

endpackage

`default_nettype wire

// ===== hdl/ptlpb_front.sv =====
// ----------------------------------------------------------------------------
// ptlpb_front: request decode and TLP assembly
// Accepts one request beat, classifies it and builds the full list of TLP
// dwords with its length, byte enables, tag and payload placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptlpb_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [ptlpb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                               csr_we,
   input  wire logic [ptlpb_pkg::RID_W-1:0]        csr_wdata,
   input  wire ptlpb_pkg::ptlpb_qstat_type         qstat,
   output logic                                    push,
   output ptlpb_pkg::ptlpb_desc_type               push_desc
);
   import ptlpb_pkg::*;

   logic [RID_W-1:0] rid_ff, rid_in;
   logic [7:0]       tag_ff, tag_in;

   logic [1:0]   cmd;
   logic [63:0]  addr;
   logic [3:0]   size_raw, size_sat, kept;
   logic [15:0]  bdf;
   logic [63:0]  wdata, wmasked;
   logic         is_cfg, is_write, wide;
   logic [1:0]   off;
   logic [2:0]   room, first_n, rem_n, hdr_n, count, p;
   logic [4:0]   sum, lo_first, lo_last, sum3;
   logic [7:0]   be8;
   logic [3:0]   lead_be, last_be;
   logic [1:0]   mem_dwords, dwords;
   logic [2:0]   fmt;
   logic [4:0]   tlp_type;
   logic [95:0]  pay;
   ptlpb_word_type [PAY_WORDS-1:0] pay_word;
   ptlpb_word_type [3:0]           hw;

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      cmd      = req_tdata[1:0];
      addr     = req_tdata[65:2];
      size_raw = req_tdata[69:66];
      bdf      = req_tdata[85:70];
      wdata    = req_tdata[149:86];

      is_cfg   = (cmd == CMD_CFG_RD) || (cmd == CMD_CFG_WR);
      is_write = (cmd == CMD_CFG_WR) || (cmd == CMD_MEM_WR);
      wide     = !is_cfg && (addr[63:32] != 32'd0);

      // saturate size into 1..MAX_ACCESS_BYTES
      if (size_raw == 4'd0) begin
         size_sat = 4'd1;
      end else if (size_raw > MAX_ACCESS_BYTES) begin
         size_sat = MAX_ACCESS_BYTES;
      end else begin
         size_sat = size_raw;
      end

      off      = addr[1:0];
      room     = 3'd4 - {1'b0, off};
      first_n  = (size_sat < {1'b0, room}) ? size_sat[2:0] : room;
      lo_first = (5'd1 << first_n) - 5'd1;
      be8      = {4'b0, lo_first[3:0]} << off;
      lead_be  = be8[3:0];

      sum        = {1'b0, size_sat} + {3'b0, off};
      sum3       = sum + 5'd3;
      mem_dwords = sum3[3:2];
      dwords     = is_cfg ? 2'd1 : mem_dwords;

      rem_n   = (sum[1:0] == 2'd0) ? 3'd4 : {1'b0, sum[1:0]};
      lo_last = (5'd1 << rem_n) - 5'd1;
      last_be = (!is_cfg && (mem_dwords > 2'd1)) ? lo_last[3:0] : 4'd0;

      // keep only the bytes that land in the request
      kept = is_cfg ? {1'b0, first_n} : size_sat;
      for (int b = 0; b < 8; b++) begin
         wmasked[8*b +: 8] = (4'(b) < kept) ? wdata[8*b +: 8] : 8'd0;
      end
      pay = {32'd0, wmasked} << {off, 3'b000};
      for (int k = 0; k < PAY_WORDS; k++) begin
         pay_word[k] = {pay[32*k +: 8], pay[32*k+8 +: 8],
                        pay[32*k+16 +: 8], pay[32*k+24 +: 8]};
      end

      fmt      = (is_write ? FMT_WITH_DATA : 3'd0) | (wide ? FMT_4DW : 3'd0);
      tlp_type = is_cfg ? TLP_TYPE_CFG0 : TLP_TYPE_MEM;

      hw[0] = {fmt, tlp_type, 14'd0, 8'd0, dwords};
      hw[1] = {rid_ff, tag_ff, last_be, lead_be};
      if (is_cfg) begin
         hw[2] = {bdf, 4'd0, addr[11:2], 2'b00};
      end else if (wide) begin
         hw[2] = addr[63:32];
      end else begin
         hw[2] = {addr[31:2], 2'b00};
      end
      hw[3] = {addr[31:2], 2'b00};

      hdr_n = wide ? 3'd4 : 3'd3;
      count = hdr_n + (is_write ? {1'b0, dwords} : 3'd0);

      // header dwords first, payload dwords right behind them
      for (int j = 0; j < MAX_WORDS; j++) begin
         p = 3'(j) - hdr_n;
         if (j < 4 && 3'(j) < hdr_n) begin
            push_desc.words[j] = hw[j % 4];
         end else if (3'(j) >= hdr_n && p < 3'(PAY_WORDS)) begin
            push_desc.words[j] = pay_word[p[1:0]];
         end else begin
            push_desc.words[j] = 32'd0;
         end
      end
      push_desc.last_idx = count - 3'd1;
      push_desc.tag      = tag_ff;
   end

   always_comb begin
      rid_in = csr_we ? csr_wdata : rid_ff;
      tag_in = push ? tag_ff + 8'd1 : tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rid_ff <= '0;
         tag_ff <= '0;
      end else begin
         rid_ff <= rid_in;
         tag_ff <= tag_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ptlpb_queue.sv =====
// ----------------------------------------------------------------------------
// ptlpb_queue: two-entry descriptor queue
// Decouples request decode from dword emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptlpb_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire ptlpb_pkg::ptlpb_desc_type   push_desc,
   input  wire logic                        pop,
   output ptlpb_pkg::ptlpb_desc_type        head,
   output ptlpb_pkg::ptlpb_qstat_type       qstat
);
   import ptlpb_pkg::*;

   ptlpb_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head        = entry_ff[rd_ptr_ff];
   assign qstat.full  = (cnt_ff == 2'd2);
   assign qstat.empty = (cnt_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ptlpb_back.sv =====
// ----------------------------------------------------------------------------
// ptlpb_back: dword emitter
// Walks the head descriptor one dword a cycle into the output register while rsp is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptlpb_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ptlpb_pkg::ptlpb_desc_type          head,
   input  wire ptlpb_pkg::ptlpb_qstat_type         qstat,
   output logic                                    pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [ptlpb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                    rsp_tlast
);
   import ptlpb_pkg::*;

   logic [2:0]     idx_ff, idx_in;
   logic           valid_ff, valid_in;
   ptlpb_word_type word_ff, word_in;
   logic           last_ff, last_in;
   logic [7:0]     tag_ff, tag_in;
   logic           load, at_end;

   assign load   = !qstat.empty && (!valid_ff || rsp_tready);
   assign at_end = (idx_ff == head.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      tag_in   = tag_ff;
      if (load) begin
         idx_in   = at_end ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
         word_in  = head.words[idx_ff];
         last_in  = at_end;
         tag_in   = head.tag;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      last_ff <= last_in;
      tag_ff  <= tag_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {tag_ff, word_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== hdl/pcie_request_tlp_builder.sv =====
// ----------------------------------------------------------------------------
// pcie_request_tlp_builder: host request to PCIe request TLP dword stream
// Builds config and memory read/write request TLPs, one dword per beat.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------------
//   req_*   | in  | one request: command, address, access_size, bdf, data
//   rsp_*   | out | one TLP dword with its tag, tlast on the final dword
//   csr_*   | in  | requester id write, taken whenever csr_we is high
//
// A request is 3 to 7 dwords long; the back end emits one dword a cycle
// from the head of the queue while rsp_tready does not stall the output.
// The front end takes a new request every cycle while the two-entry queue
// has room, so decode of the next request overlaps emission of this one.
// Reset clears the tag counter, the requester id, the queue and the output.
// A stalled rsp beat holds in the output register while the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module pcie_request_tlp_builder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [1:0] command, [65:2] address, [69:66] access_size,
   // [85:70] target_bdf, [149:86] write_data, [151:150] zero
   input  wire logic [ptlpb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] tlp_word, [39:32] tag_used
   output logic [ptlpb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_we,
   input  wire logic [ptlpb_pkg::RID_W-1:0]        csr_wdata
);
   import ptlpb_pkg::*;

   ptlpb_desc_type  push_desc, head;
   ptlpb_qstat_type qstat;
   logic            push, pop;

   // decode and assemble the TLP, own the tag counter and requester id
   ptlpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .qstat      (qstat),
      .push       (push),
      .push_desc  (push_desc)
   );

   // hold finished descriptors between the two halves
   ptlpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   // advance through the head descriptor one dword per beat
   ptlpb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/ptlpb_checker.sv =====
// ----------------------------------------------------------------------------
// ptlpb_checker: port-level checks of the TLP builder
// Watches the output stream for framing, tag and header consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptlpb_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [ptlpb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                               rsp_tlast
);
   import ptlpb_pkg::*;

   logic                 mid_ff;
   logic [7:0]           tag_ff;
   logic                 stall;
   logic [RSP_TDATA_W:0] beat;
   logic [7:0]           beat_tag;
   logic                 hdr_ok;

   assign stall    = rsp_tvalid && !rsp_tready;
   assign beat     = {rsp_tlast, rsp_tdata};
   assign beat_tag = rsp_tdata[39:32];

   // first dword: known type, length of one to three dwords, never the last
   assign hdr_ok = (rsp_tdata[28:24] == TLP_TYPE_CFG0 || rsp_tdata[28:24] == TLP_TYPE_MEM)
                   && rsp_tdata[9:0] != 10'd0 && rsp_tdata[9:0] < 10'd4 && !rsp_tlast;

   // track whether the next beat continues a TLP and which tag it carries
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         mid_ff <= !rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         tag_ff <= beat_tag;
      end
   end

   `ASSERT_CLKD(a_rsp_hold, clock, reset, stall |=> rsp_tvalid && $stable(beat), "stalled rsp beat changed")

   `ASSERT_CLKD(a_tag_same, clock, reset, rsp_tvalid && mid_ff |-> beat_tag == tag_ff, "tag changed inside a TLP")

   `ASSERT_CLKD(a_hdr_type, clock, reset, rsp_tvalid && !mid_ff |-> hdr_ok, "bad first dword of a TLP")

   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind pcie_request_tlp_builder ptlpb_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for pcie_request_tlp_builder
// Sends config and memory read/write requests and predicts the TLP dwords that
// each one produces. Every rsp beat is compared with the oldest predicted
// dword. Both channels stall at random, and the requester id changes between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ptlpb_pkg::*;

   // one host request, packed so that command lands in the lowest bits
   typedef struct packed {
      logic [63:0] write_data;
      logic [15:0] target_bdf;
      logic [3:0]  access_size;
      logic [63:0] address;
      logic [1:0]  command;
   } host_req_type;

   typedef struct {
      logic [31:0] word;
      logic        last;
      logic [7:0]  tag;
   } tlp_dword_type;

   // Predicts the dword stream of each request and checks the beats against it.
   class tlp_checker;
      tlp_dword_type due[$];
      logic [7:0]    tag_count;
      logic [15:0]   rid_value;
      int            errors;

      function new();
         tag_count = 8'd0;
         rid_value = 16'd0;
         errors    = 0;
      endfunction

      function void report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endfunction

      // Build the TLP for one accepted request and queue its dwords.
      function void note_request(host_req_type r);
         logic [3:0]    size;
         logic [1:0]    off;
         int            first_n, dwords, kept, rem;
         logic [3:0]    lead_be, last_be;
         logic [2:0]    fmt;
         logic [4:0]    tlp_type;
         logic [7:0]    payload[16];
         logic [31:0]   words[$];
         logic          is_cfg, is_wr;
         logic [7:0]    tag;
         tlp_dword_type d;

         size = r.access_size;
         if (size == 4'd0) size = 4'd1;
         if (size > MAX_ACCESS_BYTES) size = MAX_ACCESS_BYTES;
         tag       = tag_count;
         tag_count = tag_count + 8'd1;
         is_cfg    = (r.command == CMD_CFG_RD) || (r.command == CMD_CFG_WR);
         is_wr     = (r.command == CMD_CFG_WR) || (r.command == CMD_MEM_WR);

         off      = r.address[1:0];
         first_n  = (int'(size) < 4 - int'(off)) ? int'(size) : 4 - int'(off);
         lead_be  = 4'(((1 << first_n) - 1) << off);
         last_be  = 4'd0;

         // config requests never leave their dword: spilled bytes are dropped
         if (is_cfg) begin
            dwords   = 1;
            kept     = first_n;
            tlp_type = TLP_TYPE_CFG0;
         end else begin
            dwords   = (int'(off) + int'(size) + 3) / 4;
            kept     = int'(size);
            tlp_type = TLP_TYPE_MEM;
            if (dwords > 1) begin
               rem = (int'(size) - (4 - int'(off))) % 4;
               if (rem == 0) rem = 4;
               last_be = 4'((1 << rem) - 1);
            end
         end

         for (int i = 0; i < 16; i++) payload[i] = 8'd0;
         for (int i = 0; i < kept; i++) payload[int'(off) + i] = r.write_data[8*i +: 8];

         fmt = is_wr ? FMT_WITH_DATA : 3'd0;
         if (!is_cfg && r.address[63:32] != 32'd0) fmt = fmt | FMT_4DW;

         words.push_back({fmt, tlp_type, 14'd0, 10'(dwords)});
         words.push_back({rid_value, tag, last_be, lead_be});
         if (is_cfg) begin
            words.push_back({r.target_bdf, 4'd0, r.address[11:2], 2'b00});
         end else begin
            if ((fmt & FMT_4DW) != 3'd0) words.push_back(r.address[63:32]);
            words.push_back({r.address[31:2], 2'b00});
         end
         if (is_wr) begin
            for (int k = 0; k < dwords; k++)
               words.push_back({payload[4*k], payload[4*k+1], payload[4*k+2],
                                payload[4*k+3]});
         end

         for (int k = 0; k < words.size(); k++) begin
            d.word = words[k];
            d.last = (k == words.size() - 1);
            d.tag  = tag;
            due.push_back(d);
         end
      endfunction

      function void check_dword(logic [RSP_TDATA_W-1:0] beat, logic last);
         tlp_dword_type want;
         if (due.size() == 0) begin
            report($sformatf("dword %h arrived with nothing pending", beat[31:0]));
            return;
         end
         want = due.pop_front();
         if (beat[31:0] !== want.word)
            report($sformatf("tlp_word %h, predicted %h", beat[31:0], want.word));
         if (beat[39:32] !== want.tag)
            report($sformatf("tag_used %h, predicted %h", beat[39:32], want.tag));
         if (last !== want.last)
            report($sformatf("tlast %b, predicted %b on dword %h", last, want.last,
                             want.word));
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [RID_W-1:0]        csr_wdata = '0;

   // when set, neither side inserts idle cycles
   logic                    steady_flow = 1'b0;

   tlp_checker board = new();

   pcie_request_tlp_builder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Result side: check each accepted beat, then pick the next ready level.
   // Sampling right after the edge sees the values that the edge used.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_dword(rsp_tdata, rsp_tlast);
         if (steady_flow) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 37);
         end
      end
   end

   function automatic host_req_type make_req(logic [1:0] cmd, logic [63:0] addr,
                                             logic [3:0] size, logic [15:0] bdf,
                                             logic [63:0] wdata);
      host_req_type r;
      r.command     = cmd;
      r.address     = addr;
      r.access_size = size;
      r.target_bdf  = bdf;
      r.write_data  = wdata;
      return r;
   endfunction

   function automatic host_req_type random_req();
      host_req_type r;
      int           pick;
      r.command = 2'($urandom_range(3));
      pick = $urandom_range(99);
      // mostly legal sizes, now and then zero or oversized
      if (pick < 80) begin
         r.access_size = 4'($urandom_range(8, 1));
      end else if (pick < 90) begin
         r.access_size = 4'd0;
      end else begin
         r.access_size = 4'($urandom_range(15, 9));
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.address = {32'd0, 32'($urandom)};
      end else if (pick < 80) begin
         r.address = {32'($urandom), 32'($urandom)};
      end else if (pick < 90) begin
         r.address = {32'($urandom), 28'hFFFFFFF, 4'($urandom_range(15))};
      end else begin
         r.address = {32'($urandom_range(3)), 32'($urandom_range(4095))};
      end
      r.target_bdf = 16'($urandom);
      r.write_data = {32'($urandom), 32'($urandom)};
      return r;
   endfunction

   // Present one request beat, with random idle cycles ahead of it.
   task automatic send_request(host_req_type r);
      while (!steady_flow && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(r);
   endtask

   // Drop valid, then hold until every predicted dword has left and the
   // pipeline has had time to settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_rid(logic [RID_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.rid_value = value;
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_request(random_req());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, every command, size clamping and config spill.
      write_rid(16'hFFFF);
      send_request(make_req(CMD_CFG_RD, 64'h0, 4'd4, 16'h0000, 64'h0));
      send_request(make_req(CMD_CFG_RD, 64'hFFFF_FFFF_FFFF_F001, 4'd1, 16'hFFFF, 64'h0));
      send_request(make_req(CMD_CFG_WR, 64'h3, 4'd4, 16'h1234, 64'h11223344));
      send_request(make_req(CMD_CFG_WR, 64'h2, 4'd0, 16'h00FF, 64'hFFFF_FFFF_FFFF_FFFF));
      send_request(make_req(CMD_CFG_WR, 64'hFFE, 4'd15, 16'hFFFF,
                            64'hFFFF_FFFF_FFFF_FFFF));
      send_request(make_req(CMD_CFG_RD, 64'hFFC, 4'd8, 16'h8001, 64'hFFFF));
      send_request(make_req(CMD_CFG_WR, 64'h801, 4'd3, 16'h5A5A, 64'h00A1_B2C3_D4E5_F607));
      send_request(make_req(CMD_CFG_RD, 64'h7, 4'd0, 16'hA5A5, 64'h0));
      send_request(make_req(CMD_MEM_RD, 64'h0, 4'd1, 16'h0, 64'h0));
      send_request(make_req(CMD_MEM_RD, 64'hFFFF_FFFF, 4'd8, 16'h0, 64'h0));
      send_request(make_req(CMD_MEM_RD, 64'h1_0000_0000, 4'd4, 16'hFFFF, 64'h0));
      send_request(make_req(CMD_MEM_RD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'h0,
                            64'hFFFF_FFFF_FFFF_FFFF));
      send_request(make_req(CMD_MEM_RD, 64'h8000_0000_0000_0000, 4'd7, 16'h0, 64'h0));
      send_request(make_req(CMD_MEM_WR, 64'h0, 4'd4, 16'h0, 64'h0123_4567_89AB_CDEF));
      send_request(make_req(CMD_MEM_WR, 64'h2, 4'd6, 16'h0, 64'hFEDC_BA98_7654_3210));
      send_request(make_req(CMD_MEM_WR, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'h0,
                            64'hFFFF_FFFF_FFFF_FFFF));
      send_request(make_req(CMD_MEM_WR, 64'h1_0000_0001, 4'd5, 16'hFFFF,
                            64'h8877_6655_4433_2211));
      send_request(make_req(CMD_MEM_WR, 64'h8000_0000, 4'd0, 16'h0, 64'h0000_0000_0000_00AB));
      send_request(make_req(CMD_MEM_WR, 64'h4, 4'd12, 16'h0, 64'h0102_0304_0506_0708));
      send_request(make_req(CMD_MEM_WR, 64'h5, 4'd2, 16'h0, 64'hFFFF_FFFF_FFFF_0000));
      wait_idle();

      // Random phases, each with its own requester id.
      write_rid(16'h0000);
      send_random(120);
      wait_idle();

      // Long stretch with both sides always ready.
      write_rid(16'($urandom));
      steady_flow <= 1'b1;
      send_random(80);
      wait_idle();

      steady_flow <= 1'b0;
      write_rid(16'h8001);
      send_random(150);
      wait_idle();

      if (board.pending() != 0) board.report("dwords still pending at end of run");
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
